// ===== hdl/homogeneous_point_transform_macros.svh =====
// Assertion helpers for the point transform.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define HPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define HPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hdl/hpt_pkg.sv =====
`default_nettype none
package hpt_pkg;
    localparam int unsigned NUM_REGS    = 8;
    localparam int unsigned ADDR_W      = 5;
    localparam int unsigned DIV_STAGES  = 64;
    localparam int unsigned ACC_W       = 50;
    localparam int unsigned NUM_W       = 65;
    localparam logic [63:0] S32_MAX_MAG = 64'h7FFF_FFFF;
    localparam logic [63:0] S32_MIN_MAG = 64'h8000_0000;
    localparam logic [31:0] CFG_RESET [NUM_REGS] = '{
        32'h0000_1000, 32'h0, 32'h1000_0000, 32'h0,
        32'h0, 32'h0000_1000, 32'h0, 32'h1000_0000};

    typedef struct packed {
        logic        w_zero;
        logic        x_neg;
        logic        y_neg;
        logic        z_neg;
    } t_sign_info;
endpackage
`default_nettype wire

// ===== hdl/hpt_if.sv =====
`default_nettype none
interface hpt_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    modport source (output valid, in_x, in_y, in_z, input ready);
    modport sink (input valid, in_x, in_y, in_z, output ready);
endinterface

interface hpt_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               w_zero;
    logic               saturated;
    modport source (output valid, out_x, out_y, out_z, w_zero, saturated, input ready);
    modport sink (input valid, out_x, out_y, out_z, w_zero, saturated, output ready);
endinterface
`default_nettype wire

// ===== hdl/hpt_lane.sv =====
`default_nettype none
// One matrix column: dot product (registered products, then sum) and a
// pipelined restoring divide of |acc|*2^16 by |W|, one quotient bit a stage.
module hpt_lane (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic signed [31:0]                  i_x,
    input  wire logic signed [31:0]                  i_y,
    input  wire logic signed [31:0]                  i_z,
    input  wire logic signed [15:0]                  i_m1,
    input  wire logic signed [15:0]                  i_m2,
    input  wire logic signed [15:0]                  i_m3,
    input  wire logic signed [15:0]                  i_m4,
    output      logic signed [hpt_pkg::ACC_W-1:0]    o_acc,
    input  wire logic        [hpt_pkg::ACC_W-1:0]    i_den,
    output      logic        [hpt_pkg::DIV_STAGES-1:0] o_quo
);
    localparam int unsigned S = hpt_pkg::DIV_STAGES;
    localparam int unsigned W = hpt_pkg::ACC_W;

    logic signed [47:0] r_p1, r_p2, r_p3, r_p4;
    logic signed [W-1:0] r_acc;
    logic [S-1:0]  r_num  [S+1];
    logic [W:0]    r_rem  [S+1];
    logic [S-1:0]  r_q    [S+1];
    logic [W-1:0]  r_den  [S+1];
    logic [S-1:0]  n_num;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1 <= i_x * i_m1;
            r_p2 <= i_y * i_m2;
            r_p3 <= i_z * i_m3;
            r_p4 <= 48'(i_m4) <<< 16;
            r_acc <= W'(r_p1) + W'(r_p2) + W'(r_p3) + W'(r_p4);
        end
    end
    assign o_acc = r_acc;

    // The magnitude is below 2^48, so its low 48 bits followed by 16 zero
    // bits form the full 64-bit numerator |acc|*2^16.
    always_comb begin
        n_num = S'({(r_acc[W-1] ? W'(-r_acc) : W'(r_acc)), 16'h0000});
    end

    // Stage 0 takes the magnitude numerator already scaled by 2^16.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= n_num;
            r_rem[0] <= '0;
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            for (int k = 0; k < S; k++) begin
                logic [W:0] t;
                t = {r_rem[k][W-1:0], r_num[k][S-1]};
                if (t >= {1'b0, r_den[k]}) begin
                    r_rem[k+1] <= t - {1'b0, r_den[k]};
                    r_q[k+1]   <= {r_q[k][S-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= t;
                    r_q[k+1]   <= {r_q[k][S-2:0], 1'b0};
                end
                r_num[k+1] <= {r_num[k][S-2:0], 1'b0};
                r_den[k+1] <= r_den[k];
            end
        end
    end
    assign o_quo = r_q[S];
endmodule
`default_nettype wire

// ===== hdl/hpt_merge.sv =====
`default_nettype none
// Signs the three quotients, clamps them and folds the flags.
module hpt_merge (
    input  wire logic [hpt_pkg::DIV_STAGES-1:0] i_qx,
    input  wire logic [hpt_pkg::DIV_STAGES-1:0] i_qy,
    input  wire logic [hpt_pkg::DIV_STAGES-1:0] i_qz,
    input  wire hpt_pkg::t_sign_info            i_info,
    output      logic [31:0]                    o_x,
    output      logic [31:0]                    o_y,
    output      logic [31:0]                    o_z,
    output      logic                           o_sat
);
    logic sx, sy, sz;

    function automatic logic [32:0] clamp(input logic [hpt_pkg::DIV_STAGES-1:0] q,
                                          input logic neg);
        logic [63:0] qq;
        qq = 64'(q);
        if (!neg) begin
            if (qq > hpt_pkg::S32_MAX_MAG) return {1'b1, 32'h7FFF_FFFF};
            return {1'b0, qq[31:0]};
        end
        if (qq > hpt_pkg::S32_MIN_MAG) return {1'b1, 32'h8000_0000};
        return {1'b0, 32'(-qq)};
    endfunction

    always_comb begin
        {sx, o_x} = clamp(i_qx, i_info.x_neg);
        {sy, o_y} = clamp(i_qy, i_info.y_neg);
        {sz, o_z} = clamp(i_qz, i_info.z_neg);
        o_sat = sx | sy | sz;
        if (i_info.w_zero) begin
            o_x = '0;
            o_y = '0;
            o_z = '0;
            o_sat = 1'b0;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/homogeneous_point_transform.sv =====
// Products register at the edge that accepts a request; then come 1 sum stage,
// 1 sign stage, 64 divider stages and 1 output register before result valid.
// Throughput: one request per cycle; the whole pipeline advances together
// and stalls only when the output register is full and not being taken.
// Reset (synchronous, active low) clears valids and loads the identity matrix.
`default_nettype none
`include "homogeneous_point_transform_macros.svh"
module homogeneous_point_transform (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    hpt_in_if.sink                          i_req,
    hpt_out_if.source                       o_res,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [hpt_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output      logic [31:0]                prdata,
    output      logic                       pready
);
    // The divider needs one stage per bit of the 64-bit numerator.
    localparam int unsigned P_STAGES = hpt_pkg::DIV_STAGES;
    // Total pipeline depth before the output register.
    localparam int unsigned DEPTH = P_STAGES + 3;
    localparam int unsigned W = hpt_pkg::ACC_W;

    logic [31:0] r_cfg [hpt_pkg::NUM_REGS];
    logic [2:0]  cfg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = r_cfg[cfg_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hpt_pkg::NUM_REGS; i++) r_cfg[i] <= hpt_pkg::CFG_RESET[i];
        end else if (cfg_wr) begin
            r_cfg[cfg_idx] <= pwdata;
        end
    end

    // The whole pipeline moves when the output stage is empty or being drained.
    logic en;
    logic [DEPTH-1:0] r_vld;
    logic r_out_vld;
    assign en = !r_out_vld || o_res.ready;
    assign i_req.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_req.valid};
        end
    end

    // Four lanes, one per matrix column; lane 3 computes W.
    logic signed [W-1:0] acc [4];
    logic [P_STAGES-1:0] quo [4];
    logic [W-1:0] den_mag;
    hpt_pkg::t_sign_info r_info [P_STAGES+1];

    for (genvar c = 0; c < 4; c++) begin : g_lane
        hpt_lane u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (i_req.in_x),
            .i_y   (i_req.in_y),
            .i_z   (i_req.in_z),
            .i_m1  (r_cfg[c/2][16*(c%2) +: 16]),
            .i_m2  (r_cfg[2 + c/2][16*(c%2) +: 16]),
            .i_m3  (r_cfg[4 + c/2][16*(c%2) +: 16]),
            .i_m4  (r_cfg[6 + c/2][16*(c%2) +: 16]),
            .o_acc (acc[c]),
            .i_den (den_mag),
            .o_quo (quo[c])
        );
    end

    // |W| and the quotient signs line up with the divider's first stage.
    always_comb begin
        den_mag = acc[3][W-1] ? W'(-acc[3]) : W'(acc[3]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_info[0].w_zero <= (acc[3] == '0);
            r_info[0].x_neg  <= acc[0][W-1] ^ acc[3][W-1];
            r_info[0].y_neg  <= acc[1][W-1] ^ acc[3][W-1];
            r_info[0].z_neg  <= acc[2][W-1] ^ acc[3][W-1];
            for (int k = 0; k < P_STAGES; k++) r_info[k+1] <= r_info[k];
        end
    end

    logic [31:0] mx, my, mz;
    logic msat;
    hpt_merge u_merge (
        .i_qx   (quo[0]),
        .i_qy   (quo[1]),
        .i_qz   (quo[2]),
        .i_info (r_info[P_STAGES]),
        .o_x    (mx),
        .o_y    (my),
        .o_z    (mz),
        .o_sat  (msat)
    );

    logic [31:0] r_ox, r_oy, r_oz;
    logic r_wz, r_sat;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[DEPTH-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ox  <= mx;
            r_oy  <= my;
            r_oz  <= mz;
            r_wz  <= r_info[P_STAGES].w_zero;
            r_sat <= msat;
        end
    end

    assign o_res.valid     = r_out_vld;
    assign o_res.out_x     = r_ox;
    assign o_res.out_y     = r_oy;
    assign o_res.out_z     = r_oz;
    assign o_res.w_zero    = r_wz;
    assign o_res.saturated = r_sat;

    // A result is held while the receiver stalls, and one with W zero
    // reports zeros without saturation.
    logic res_hold, res_wz;
    assign res_hold = o_res.valid && !o_res.ready;
    assign res_wz   = o_res.valid && o_res.w_zero;

    `HPT_ASSERT_IMP(a_wz_nosat, i_clk, i_rst_n, res_wz, !o_res.saturated)
    `HPT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, res_hold, o_res.valid && $stable(o_res.out_x))
    `HPT_ASSERT_IMP(a_wz_zero, i_clk, i_rst_n, res_wz, o_res.out_x == 32'h0)
endmodule
`default_nettype wire

// ===== test/tb_scoreboard.sv =====
`timescale 1ns / 1ps
// Holds the transform matrix and the queue of predicted points.
class point_scoreboard;
    bit [31:0] matrix_regs [8];
    bit [31:0] exp_x [$];
    bit [31:0] exp_y [$];
    bit [31:0] exp_z [$];
    bit        exp_wz [$];
    bit        exp_sat [$];
    int        mismatches;

    function void load_identity();
        matrix_regs = '{32'h0000_1000, 32'h0, 32'h1000_0000, 32'h0,
                        32'h0, 32'h0000_1000, 32'h0, 32'h1000_0000};
    endfunction

    function longint entry(int r, int c);
        bit [31:0] reg_val;
        bit signed [15:0] half;
        reg_val = matrix_regs[r * 2 + c / 2];
        half = (c % 2) ? reg_val[31:16] : reg_val[15:0];
        return longint'(half);
    endfunction

    function bit [31:0] divide_clamp(longint num, longint den, inout bit sat);
        bit [63:0] nmag;
        bit [63:0] dmag;
        bit [63:0] q;
        nmag = (num < 0) ? -num : num;
        dmag = (den < 0) ? -den : den;
        q = (nmag << 16) / dmag;
        if ((num < 0) == (den < 0)) begin
            if (q > 64'h7FFF_FFFF) begin
                sat = 1;
                return 32'h7FFF_FFFF;
            end
            return q[31:0];
        end
        if (q > 64'h8000_0000) begin
            sat = 1;
            return 32'h8000_0000;
        end
        return -q[31:0];
    endfunction

    // A request was accepted: project the point and queue the result.
    function void note_point(bit [31:0] x, bit [31:0] y, bit [31:0] z);
        longint p [3];
        longint acc [4];
        bit sat;
        p[0] = longint'(signed'(x));
        p[1] = longint'(signed'(y));
        p[2] = longint'(signed'(z));
        sat = 0;
        for (int c = 0; c < 4; c++)
            acc[c] = p[0] * entry(0, c) + p[1] * entry(1, c) + p[2] * entry(2, c)
                   + entry(3, c) * 65536;
        if (acc[3] == 0) begin
            exp_x.push_back(0); exp_y.push_back(0); exp_z.push_back(0);
            exp_wz.push_back(1); exp_sat.push_back(0);
        end else begin
            exp_x.push_back(divide_clamp(acc[0], acc[3], sat));
            exp_y.push_back(divide_clamp(acc[1], acc[3], sat));
            exp_z.push_back(divide_clamp(acc[2], acc[3], sat));
            exp_wz.push_back(0); exp_sat.push_back(sat);
        end
    endfunction

    function void fail(string what);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    function void check_point(bit [31:0] x, bit [31:0] y, bit [31:0] z, bit wz, bit sat);
        bit [31:0] ex, ey, ez;
        bit ew, es;
        if (exp_x.size() == 0) begin
            fail($sformatf("unexpected result x=%h y=%h z=%h", x, y, z));
            return;
        end
        ex = exp_x.pop_front(); ey = exp_y.pop_front(); ez = exp_z.pop_front();
        ew = exp_wz.pop_front(); es = exp_sat.pop_front();
        if (x != ex) fail($sformatf("out_x exp %h got %h", ex, x));
        if (y != ey) fail($sformatf("out_y exp %h got %h", ey, y));
        if (z != ez) fail($sformatf("out_z exp %h got %h", ez, z));
        if (wz != ew) fail($sformatf("w_zero exp %b got %b", ew, wz));
        if (sat != es) fail($sformatf("saturated exp %b got %b", es, sat));
    endfunction
endclass

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
    // Register indexes in the order the matrix rows are packed.
    localparam int REG_R1_C12 = 0;
    localparam int REG_R1_C34 = 1;
    localparam int REG_R2_C12 = 2;
    localparam int REG_R2_C34 = 3;
    localparam int REG_R3_C12 = 4;
    localparam int REG_R3_C34 = 5;
    localparam int REG_R4_C12 = 6;
    localparam int REG_R4_C34 = 7;
    localparam int PIPE_DEPTH = 68;
    localparam int STALL_LIMIT = 20000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [hpt_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    hpt_in_if  req_if ();
    hpt_out_if res_if ();

    homogeneous_point_transform dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if.sink), .o_res(res_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 i_clk = ~i_clk;

    point_scoreboard board;
    int sender_idle_pct;   // chance per cycle that the sender holds off
    int receiver_stall_pct; // chance per cycle that the receiver stalls
    int idle_cycles;

    initial begin
        req_if.valid = 0;
        req_if.in_x = '0;
        req_if.in_y = '0;
        req_if.in_z = '0;
        res_if.ready = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        board = new();
        board.load_identity();
    end

    // The receiver picks ready fresh on every edge and checks what it took.
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            board.check_point(res_if.out_x, res_if.out_y, res_if.out_z,
                              res_if.w_zero, res_if.saturated);
        res_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watchdog: cycles in a row with no handshake on either side.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // APB write: setup cycle, then access cycle held until pready.
    // Back-to-back writes go straight from one access cycle to the next setup.
    task automatic write_reg(int idx, logic [31:0] value);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= hpt_pkg::ADDR_W'(idx * 4); pwdata <= value;
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        board.matrix_regs[idx] = value;
    endtask

    // The bus goes idle after the last write.
    task automatic load_matrix(logic [31:0] vals [8]);
        for (int i = 0; i < 8; i++) write_reg(i, vals[i]);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge i_clk);
    endtask

    // Offer one point; hold it until the block takes it.
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        while ($urandom_range(99) < sender_idle_pct) begin
            req_if.valid <= 0;
            @(posedge i_clk);
        end
        req_if.valid <= 1;
        req_if.in_x <= x; req_if.in_y <= y; req_if.in_z <= z;
        do @(posedge i_clk); while (!req_if.ready);
        board.note_point(x, y, z);
    endtask

    // Let the pipeline empty before the matrix is touched again.
    task automatic drain();
        req_if.valid <= 0;
        while (board.exp_x.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] any_coord();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(2 * 65536 * 8)) - 65536 * 8);
            3: return 32'($signed($urandom_range(2 * 65536 * 300)) - 65536 * 300);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] any_entry();
        case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(8192)) - 4096);
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        logic [31:0] mat [8];
        logic [31:0] dir_pts [12][3];
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed points through the identity matrix: field extremes and
        // a w of zero never happens here, so a perspective matrix follows.
        dir_pts = '{
            '{32'h0, 32'h0, 32'h0},
            '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000},
            '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF},
            '{32'hFFFF_FFFF, 32'h1, 32'h8000_0000},
            '{32'h0001_8000, 32'hFFFE_8000, 32'h0003_0000},
            '{32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678},
            '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF},
            '{32'hFFFF_0000, 32'h0001_0000, 32'h0000_0000},
            '{32'h0002_0000, 32'h0, 32'hFFFE_0000},
            '{32'h0, 32'h0, 32'h0001_0000},
            '{32'h0000_8000, 32'h0000_4000, 32'hFFFF_8000},
            '{32'h1, 32'hFFFF_FFFF, 32'h0000_0002}};
        for (int i = 0; i < 12; i++) send_point(dir_pts[i][0], dir_pts[i][1], dir_pts[i][2]);
        drain();

        // Perspective matrix: w = z, so z = 0 gives w zero and small z saturates.
        mat = '{32'h0000_1000, 32'h0, 32'h1000_0000, 32'h0,
                32'h0, 32'h1000_1000, 32'h0, 32'h0};
        load_matrix(mat);
        for (int i = 0; i < 12; i++) send_point(dir_pts[i][0], dir_pts[i][1], dir_pts[i][2]);
        drain();

        // Extreme matrix: all entries at the largest and smallest values.
        mat = '{32'h8000_7FFF, 32'h7FFF_8000, 32'h7FFF_7FFF, 32'h8000_8000,
                32'h8000_7FFF, 32'h7FFF_8000, 32'h7FFF_8000, 32'h8000_7FFF};
        load_matrix(mat);
        for (int i = 0; i < 12; i++) send_point(dir_pts[i][0], dir_pts[i][1], dir_pts[i][2]);
        drain();

        // Random phases, each with its own random matrix and one of four idling mixes.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 58; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 58; end
                default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
            endcase
            for (int r = 0; r < 8; r++) mat[r] = {any_entry(), any_entry()};
            // Phase 2 ties w to z alone and often sends z zero, so w is often zero to hit the special cases.
            if (phase == 2) begin
                mat[REG_R1_C34][31:16] = 16'h0;
                mat[REG_R2_C34][31:16] = 16'h0;
                mat[REG_R3_C34][31:16] = 16'h1000;
                mat[REG_R4_C34][31:16] = 16'h0;
            end
            if (phase == 5) load_matrix('{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
                                           32'h0, 32'h0, 32'h0, 32'h0});
            load_matrix(mat);
            for (int n = 0; n < 82; n++) begin
                if (phase == 2 && n % 4 == 0)
                    send_point(any_coord(), any_coord(), 32'h0);
                else
                    send_point(any_coord(), any_coord(), any_coord());
            end
            drain();
        end

        if (board.mismatches == 0 && board.exp_x.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial idle_cycles = 0;
endmodule

// ===== homogeneous_point_transform.f =====
+incdir+hdl
hdl/hpt_pkg.sv
hdl/hpt_if.sv
hdl/hpt_lane.sv
hdl/hpt_merge.sv
hdl/homogeneous_point_transform.sv
test/tb_scoreboard.sv
test/tb.sv
